// ----- rtl/polygon_outline_transform_assert.svh -----
// assertion macros for the polygon outline transform rtl
`ifndef POLYGON_OUTLINE_TRANSFORM_ASSERT_SVH
`define POLYGON_OUTLINE_TRANSFORM_ASSERT_SVH

// same-cycle implication, disabled during reset
`define POT_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pot: same-cycle check failed");

// next-cycle implication, disabled during reset
`define POT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pot: next-cycle check failed");

`endif

// ----- rtl/pot_pkg.sv -----
// types, constants and helper functions for the polygon outline transform
`default_nettype none

package pot_pkg;

  localparam int TABLE_LEN   = 20;
  localparam int IDX_W       = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int GAIN_Q16    = 39797;

  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [11:0]        scale;
    logic [15:0]        angle;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [31:0]        line_color;
    logic               is_last;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [31:0]        segment_color;
    logic               final_segment;
  } out_beat_t;

  // one classified vertex with the parameters of its polygon
  typedef struct packed {
    logic signed [15:0] vertex_x;
    logic signed [15:0] vertex_y;
    logic [11:0]        scale;
    logic [15:0]        angle;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [31:0]        color;
    logic               first;
    logic               last;
  } q_entry_t;

  // arctan(2^-i) as a 32-bit fraction of a full turn
  function automatic logic [31:0] arctan_turn(input logic [IDX_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'h20000000;
      5'd1:    r = 32'h12E4051E;
      5'd2:    r = 32'h09FB385B;
      5'd3:    r = 32'h051111D4;
      5'd4:    r = 32'h028B0D43;
      5'd5:    r = 32'h0145D7E1;
      5'd6:    r = 32'h00A2F61E;
      5'd7:    r = 32'h00517C55;
      5'd8:    r = 32'h0028BE53;
      5'd9:    r = 32'h00145F2F;
      5'd10:   r = 32'h000A2F98;
      5'd11:   r = 32'h000517CC;
      5'd12:   r = 32'h00028BE6;
      5'd13:   r = 32'h000145F3;
      5'd14:   r = 32'h0000A2FA;
      5'd15:   r = 32'h0000517D;
      5'd16:   r = 32'h000028BE;
      5'd17:   r = 32'h0000145F;
      5'd18:   r = 32'h00000A30;
      5'd19:   r = 32'h00000518;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // clamp to the signed 16-bit screen range
  function automatic logic signed [15:0] sat16(input logic signed [21:0] v);
    logic signed [15:0] r;
    if (v > 22'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -22'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/pot_front.sv -----
// front end: takes vertex beats, marks the first of a polygon, holds its parameters
`default_nettype none

module pot_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              vertex_valid,
  output logic                   vertex_ready,
  input  wire pot_pkg::in_beat_t vertex,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output pot_pkg::q_entry_t      push_entry
);

  logic               in_polygon;
  logic [11:0]        held_scale;
  logic [15:0]        held_angle;
  logic signed [15:0] held_center_x;
  logic signed [15:0] held_center_y;
  logic [31:0]        held_color;
  logic               take;

  assign vertex_ready = push_ready;
  assign push_valid   = vertex_valid;
  assign take         = vertex_valid && push_ready;

  always_comb begin
    push_entry.vertex_x = vertex.vertex_x;
    push_entry.vertex_y = vertex.vertex_y;
    push_entry.first    = !in_polygon;
    push_entry.last     = vertex.is_last;
    if (in_polygon) begin
      push_entry.scale    = held_scale;
      push_entry.angle    = held_angle;
      push_entry.center_x = held_center_x;
      push_entry.center_y = held_center_y;
      push_entry.color    = held_color;
    end else begin
      push_entry.scale    = vertex.scale;
      push_entry.angle    = vertex.angle;
      push_entry.center_x = vertex.center_x;
      push_entry.center_y = vertex.center_y;
      push_entry.color    = vertex.line_color;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_polygon <= 1'b0;
    end else if (take) begin
      in_polygon <= !vertex.is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !in_polygon) begin
      held_scale    <= vertex.scale;
      held_angle    <= vertex.angle;
      held_center_x <= vertex.center_x;
      held_center_y <= vertex.center_y;
      held_color    <= vertex.line_color;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pot_queue.sv -----
// short queue of classified vertices between front and back
`default_nettype none

module pot_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire pot_pkg::q_entry_t push_entry,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output pot_pkg::q_entry_t      pop_entry
);

  localparam int DEPTH = pot_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pot_pkg::q_entry_t slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              push;
  logic              pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/pot_back.sv -----
// back end: cordic rotation, shared multiplier transform and segment output
`default_nettype none

module pot_back #(
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 14
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              entry_valid,
  output logic                   entry_ready,
  input  wire pot_pkg::q_entry_t entry,
  output logic                   segment_valid,
  input  wire logic              segment_ready,
  output pot_pkg::out_beat_t     segment
);

  localparam int AW    = ANGLE_BITS;
  localparam int ITERS = (TRIG_ITERATIONS > pot_pkg::TABLE_LEN) ?
                         pot_pkg::TABLE_LEN : TRIG_ITERATIONS;
  localparam int TSH   = 32 - AW;
  localparam int CW    = pot_pkg::IDX_W;
  localparam int XW    = 19;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROT   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_EMIT2 = 3'd4;

  localparam logic [CW-1:0] M_SX   = CW'(0);
  localparam logic [CW-1:0] M_SY   = CW'(1);
  localparam logic [CW-1:0] M_XC   = CW'(2);
  localparam logic [CW-1:0] M_YS   = CW'(3);
  localparam logic [CW-1:0] M_XS   = CW'(4);
  localparam logic [CW-1:0] M_YC   = CW'(5);
  localparam logic [CW-1:0] M_ACC  = CW'(6);
  localparam logic [CW-1:0] M_RND  = CW'(7);
  localparam logic [CW-1:0] M_SAT  = CW'(8);

  logic [2:0]         state;
  logic [CW-1:0]      cnt;
  pot_pkg::q_entry_t  cur;
  logic signed [XW-1:0] x, y, c, s;
  logic signed [AW:0] z;
  logic               flip;
  logic signed [28:0] sx, sy;
  logic signed [47:0] p;
  logic signed [48:0] acc_x, acc_y;
  logic signed [20:0] rnd_x, rnd_y;
  logic signed [15:0] px, py;
  logic signed [15:0] first_x, first_y, prev_x, prev_y;

  logic               out_free;
  logic               take;
  logic               emit;

  // angle folding into [-quarter, quarter)
  logic [39:0]        ang_wide;
  logic [AW-1:0]      z_raw;
  logic signed [AW:0] z_init;
  logic               flip_init;

  // one cordic step
  logic signed [XW-1:0] x_sh, y_sh, x_next, y_next;
  logic [31:0]          at_full;
  logic [31:0]          at_shift;
  logic signed [AW:0]   step;
  logic signed [AW:0]   z_next;

  // shared multiplier
  logic signed [28:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [47:0] prod;
  logic signed [48:0] rx_bias, ry_bias;

  assign entry_ready = (state == S_IDLE);
  assign take        = entry_valid && entry_ready;
  assign out_free    = !segment_valid || segment_ready;
  // a segment beat is loaded this cycle
  assign emit        = out_free &&
                       (((state == S_EMIT) && !(cur.first && !cur.last)) ||
                        (state == S_EMIT2));

  always_comb begin
    ang_wide  = {entry.angle, 24'd0};
    z_raw     = ang_wide[39 -: AW];
    flip_init = z_raw[AW-1] ^ z_raw[AW-2];
    z_init    = {z_raw[AW-2], z_raw[AW-2], z_raw[AW-2:0]};
  end

  always_comb begin
    x_sh     = x >>> cnt;
    y_sh     = y >>> cnt;
    at_full  = pot_pkg::arctan_turn(cnt);
    at_shift = at_full >> TSH;
    step     = {1'b0, at_shift[AW-1:0]};
    if (!z[AW]) begin
      x_next = x - y_sh;
      y_next = y + x_sh;
      z_next = z - step;
    end else begin
      x_next = x + y_sh;
      y_next = y - x_sh;
      z_next = z + step;
    end
  end

  always_comb begin
    case (cnt)
      M_SX: begin
        mul_a = {{13{cur.vertex_x[15]}}, cur.vertex_x};
        mul_b = {7'd0, cur.scale};
      end
      M_SY: begin
        mul_a = {{13{cur.vertex_y[15]}}, cur.vertex_y};
        mul_b = {7'd0, cur.scale};
      end
      M_XC: begin
        mul_a = sx;
        mul_b = c;
      end
      M_YS: begin
        mul_a = sy;
        mul_b = s;
      end
      M_XS: begin
        mul_a = sx;
        mul_b = s;
      end
      M_YC: begin
        mul_a = sy;
        mul_b = c;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod    = mul_a * mul_b;
    rx_bias = acc_x + 49'sd134217728;
    ry_bias = acc_y + 49'sd134217728;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      segment_valid <= 1'b0;
    end else begin
      if (emit) begin
        segment_valid <= 1'b1;
      end else if (segment_ready) begin
        segment_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            cnt   <= '0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (cnt == CW'(ITERS - 1)) begin
            cnt   <= '0;
            state <= S_MUL;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MUL: begin
          if (cnt == M_SAT) begin
            cnt   <= '0;
            state <= S_EMIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_EMIT: begin
          if (cur.first && !cur.last) begin
            state <= S_IDLE;
          end else if (out_free) begin
            state <= (cur.last && !cur.first) ? S_EMIT2 : S_IDLE;
          end
        end
        S_EMIT2: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (take) begin
          cur  <= entry;
          x    <= XW'(pot_pkg::GAIN_Q16);
          y    <= '0;
          z    <= z_init;
          flip <= flip_init;
        end
      end
      S_ROT: begin
        x <= x_next;
        y <= y_next;
        z <= z_next;
        if (cnt == CW'(ITERS - 1)) begin
          c <= flip ? -x_next : x_next;
          s <= flip ? -y_next : y_next;
        end
      end
      S_MUL: begin
        p <= prod;
        case (cnt)
          M_SY:    sx <= p[28:0];
          M_XC:    sy <= p[28:0];
          M_YS:    acc_x <= {p[47], p};
          M_XS:    acc_x <= acc_x - {p[47], p};
          M_YC:    acc_y <= {p[47], p};
          M_ACC:   acc_y <= acc_y + {p[47], p};
          M_RND: begin
            rnd_x <= rx_bias[48:28];
            rnd_y <= ry_bias[48:28];
          end
          M_SAT: begin
            px <= pot_pkg::sat16({rnd_x[20], rnd_x} + {{6{cur.center_x[15]}}, cur.center_x});
            py <= pot_pkg::sat16({rnd_y[20], rnd_y} + {{6{cur.center_y[15]}}, cur.center_y});
          end
          default: begin
          end
        endcase
      end
      S_EMIT: begin
        if (cur.first && !cur.last) begin
          first_x <= px;
          first_y <= py;
          prev_x  <= px;
          prev_y  <= py;
        end else if (out_free) begin
          prev_x <= px;
          prev_y <= py;
          if (cur.first) begin
            first_x <= px;
            first_y <= py;
          end
          segment.segment_color <= cur.color;
          segment.end_x         <= px;
          segment.end_y         <= py;
          if (cur.first) begin
            // lone vertex: degenerate closing segment
            segment.start_x       <= px;
            segment.start_y       <= py;
            segment.final_segment <= 1'b1;
          end else begin
            segment.start_x       <= prev_x;
            segment.start_y       <= prev_y;
            segment.final_segment <= 1'b0;
          end
        end
      end
      S_EMIT2: begin
        if (out_free) begin
          segment.start_x       <= px;
          segment.start_y       <= py;
          segment.end_x         <= first_x;
          segment.end_y         <= first_y;
          segment.segment_color <= cur.color;
          segment.final_segment <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

`include "polygon_outline_transform_assert.svh"

  `POT_ASSERT_IMPLIES(a_rot_count, clk, rst, state == S_ROT, cnt < CW'(ITERS))
  `POT_ASSERT_IMPLIES(a_close_from_later, clk, rst, state == S_EMIT2, cur.last && !cur.first)
  `POT_ASSERT_NEXT(a_take_starts_rot, clk, rst, entry_valid && entry_ready, state == S_ROT)

endmodule

`default_nettype wire

// ----- rtl/polygon_outline_transform.sv -----
// Polygon outline transform: model vertices in, screen line segments out.
// The vertex channel takes one model vertex per beat with scale, angle,
// screen position and color; these are latched at the first vertex of a
// polygon and ignored on the rest. The segment channel gives one segment
// per vertex from the second on, plus the closing segment after the
// vertex marked last; a one-vertex polygon gives one degenerate segment.
// A front end classifies vertices into a two-entry queue; the back end
// runs a cordic of TRIG_ITERATIONS steps (capped at 20), then scaling,
// rotation products and sums on one shared 29x19 multiplier, rounding and
// saturation. The back end accepts a new vertex only from its idle state,
// so it works on one vertex at a time, its closing segment included.
// A stalled segment receiver holds the back end in its output state while
// the queue keeps taking up to two vertices. Synchronous reset empties the
// queue, drops any segment in flight and starts a new polygon.
`default_nettype none

module polygon_outline_transform #(
  parameter int ANGLE_BITS      = 16,
  parameter int TRIG_ITERATIONS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               vertex_valid,
  output logic                    vertex_ready,
  input  wire pot_pkg::in_beat_t  vertex,
  output logic                    segment_valid,
  input  wire logic               segment_ready,
  output pot_pkg::out_beat_t      segment
);

  logic              push_valid;
  logic              push_ready;
  pot_pkg::q_entry_t push_entry;
  logic              pop_valid;
  logic              pop_ready;
  pot_pkg::q_entry_t pop_entry;

  pot_front u_front (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertex_valid),
    .vertex_ready (vertex_ready),
    .vertex       (vertex),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_entry   (push_entry)
  );

  pot_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  pot_back #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .entry_valid   (pop_valid),
    .entry_ready   (pop_ready),
    .entry         (pop_entry),
    .segment_valid (segment_valid),
    .segment_ready (segment_ready),
    .segment       (segment)
  );

endmodule

`default_nettype wire

// ----- sim/polygon_outline_transform_tb.sv -----
// testbench for polygon_outline_transform: directed table then random polygons
`timescale 1ns / 1ps

module polygon_outline_transform_tb;

  localparam int     ANGLE_BITS      = 16;
  localparam int     TRIG_ITERATIONS = 14;
  localparam int     MAX_TRIG_STEPS  = 20;
  localparam longint CORDIC_GAIN     = 39797;
  localparam longint ROUND_HALF      = 64'sd134217728;
  localparam int     RANDOM_ITEMS    = 500;
  localparam int     PHASE_LEN       = 175;
  localparam int     DRAIN_CYCLES    = 48;
  localparam int     WATCHDOG_LIMIT  = 4000;

  typedef struct packed {
    pot_pkg::in_beat_t  beat;
    logic               typed;
    pot_pkg::out_beat_t seg_a;
    pot_pkg::out_beat_t seg_b;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               vertex_valid = 1'b0;
  logic               vertex_ready;
  pot_pkg::in_beat_t  vertex = '0;
  logic               segment_valid;
  logic               segment_ready = 1'b0;
  pot_pkg::out_beat_t segment;

  // shadow of the block's polygon state
  logic               in_polygon;
  logic signed [15:0] first_x, first_y, prev_x, prev_y;
  logic [11:0]        held_scale;
  logic [15:0]        held_angle;
  logic signed [15:0] held_center_x, held_center_y;
  logic [31:0]        held_color;

  logic [31:0] atan_turn [0:19] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  pot_pkg::out_beat_t segments_due [$];
  stim_row_t          stim_table [$];
  int                 errors = 0;
  int                 fed = 0;
  int                 send_idle_pct = 24;
  int                 recv_idle_pct = 70;
  int                 stall_cycles = 0;

  polygon_outline_transform #(
    .ANGLE_BITS      (ANGLE_BITS),
    .TRIG_ITERATIONS (TRIG_ITERATIONS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .vertex_valid  (vertex_valid),
    .vertex_ready  (vertex_ready),
    .vertex        (vertex),
    .segment_valid (segment_valid),
    .segment_ready (segment_ready),
    .segment       (segment)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic pot_pkg::in_beat_t vtx(input int x, input int y, input int scale,
                                            input int angle, input int cx, input int cy,
                                            input logic [31:0] color, input logic last);
    pot_pkg::in_beat_t r;
    r.vertex_x   = 16'(x);
    r.vertex_y   = 16'(y);
    r.scale      = 12'(scale);
    r.angle      = 16'(angle);
    r.center_x   = 16'(cx);
    r.center_y   = 16'(cy);
    r.line_color = color;
    r.is_last    = last;
    return r;
  endfunction

  function automatic pot_pkg::out_beat_t seg(input int ax, input int ay, input int bx,
                                             input int by, input logic [31:0] color,
                                             input logic fin);
    pot_pkg::out_beat_t r;
    r.start_x       = 16'(ax);
    r.start_y       = 16'(ay);
    r.end_x         = 16'(bx);
    r.end_y         = 16'(by);
    r.segment_color = color;
    r.final_segment = fin;
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_screen(input longint v);
    if (v > 32767) begin
      return 16'sh7FFF;
    end else if (v < -32768) begin
      return 16'sh8000;
    end
    return 16'(v);
  endfunction

  // rotation-mode cordic, folded into the right half plane first
  function automatic void sin_cos(input logic [15:0] ang, output longint cos_q16,
                                  output longint sin_q16);
    longint full, half, quarter, z, x, y, nx, step;
    int     steps, i;
    logic   flip;
    full    = longint'(1) << ANGLE_BITS;
    half    = full >> 1;
    quarter = full >> 2;
    if (ANGLE_BITS >= 16) begin
      z = longint'(ang) << (ANGLE_BITS - 16);
    end else begin
      z = longint'(ang) >> (16 - ANGLE_BITS);
    end
    if (z >= half) begin
      z -= full;
    end
    flip = 1'b0;
    if (z >= quarter) begin
      z -= half;
      flip = 1'b1;
    end else if (z < -quarter) begin
      z += half;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    steps = (TRIG_ITERATIONS > MAX_TRIG_STEPS) ? MAX_TRIG_STEPS : TRIG_ITERATIONS;
    for (i = 0; i < steps; i++) begin
      step = longint'(atan_turn[i] >> (32 - ANGLE_BITS));
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= step;
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += step;
      end
      x = nx;
    end
    cos_q16 = flip ? -x : x;
    sin_q16 = flip ? -y : y;
  endfunction

  function automatic void to_screen(input logic signed [15:0] vx, input logic signed [15:0] vy,
                                    output logic signed [15:0] px,
                                    output logic signed [15:0] py);
    longint c, s, sx, sy, rx, ry;
    sin_cos(held_angle, c, s);
    sx = longint'(held_scale) * longint'(vx);
    sy = longint'(held_scale) * longint'(vy);
    rx = sx * c - sy * s;
    ry = sx * s + sy * c;
    px = clamp_screen(((rx + ROUND_HALF) >>> 28) + longint'(held_center_x));
    py = clamp_screen(((ry + ROUND_HALF) >>> 28) + longint'(held_center_y));
  endfunction

  // advances the shadow state by one vertex, returns how many segments it gives
  function automatic int trace_vertex(input pot_pkg::in_beat_t v,
                                      output pot_pkg::out_beat_t seg_a,
                                      output pot_pkg::out_beat_t seg_b);
    logic signed [15:0] px, py;
    seg_a = '0;
    seg_b = '0;
    if (!in_polygon) begin
      held_scale    = v.scale;
      held_angle    = v.angle;
      held_center_x = v.center_x;
      held_center_y = v.center_y;
      held_color    = v.line_color;
      to_screen(v.vertex_x, v.vertex_y, px, py);
      first_x = px;
      first_y = py;
      prev_x  = px;
      prev_y  = py;
      if (v.is_last) begin
        seg_a = seg(px, py, px, py, held_color, 1'b1);
        return 1;
      end
      in_polygon = 1'b1;
      return 0;
    end
    to_screen(v.vertex_x, v.vertex_y, px, py);
    seg_a = seg(prev_x, prev_y, px, py, held_color, 1'b0);
    prev_x = px;
    prev_y = py;
    if (v.is_last) begin
      seg_b = seg(px, py, first_x, first_y, held_color, 1'b1);
      in_polygon = 1'b0;
      return 2;
    end
    return 1;
  endfunction

  task automatic add_row(input pot_pkg::in_beat_t b, input logic typed,
                         input pot_pkg::out_beat_t a, input pot_pkg::out_beat_t c);
    stim_row_t row;
    row.beat  = b;
    row.typed = typed;
    row.seg_a = a;
    row.seg_b = c;
    stim_table.push_back(row);
  endtask

  // offers one vertex beat, predicts its segments once it is taken
  task automatic feed(input pot_pkg::in_beat_t b, input logic typed,
                      input pot_pkg::out_beat_t ta, input pot_pkg::out_beat_t tc);
    pot_pkg::out_beat_t pa, pc;
    int                 n;
    if (fed == PHASE_LEN || fed == 2 * PHASE_LEN) begin
      // hold off until the block has drained
      vertex_valid <= 1'b0;
      do @(posedge clk); while (segments_due.size() != 0);
      send_idle_pct = (fed == PHASE_LEN) ? 70 : 0;
      recv_idle_pct = (fed == PHASE_LEN) ? 24 : 0;
    end
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      vertex_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    vertex_valid <= 1'b1;
    vertex       <= b;
    @(posedge clk);
    while (!vertex_ready) @(posedge clk);
    n = trace_vertex(b, pa, pc);
    if (typed) begin
      pa = ta;
      pc = tc;
    end
    if (n > 0) segments_due.push_back(pa);
    if (n > 1) segments_due.push_back(pc);
    fed++;
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_segment(input pot_pkg::out_beat_t got);
    pot_pkg::out_beat_t want;
    if (segments_due.size() == 0) begin
      $display("%0t: segment with none expected, expected nothing actual (%0d,%0d)-(%0d,%0d)",
               $time, got.start_x, got.start_y, got.end_x, got.end_y);
      errors++;
    end else begin
      want = segments_due.pop_front();
      compare_field("start_x", want.start_x, got.start_x);
      compare_field("start_y", want.start_y, got.start_y);
      compare_field("end_x", want.end_x, got.end_x);
      compare_field("end_y", want.end_y, got.end_y);
      compare_field("segment_color", want.segment_color, got.segment_color);
      compare_field("final_segment", want.final_segment, got.final_segment);
    end
  endtask

  // segment side: check each beat, then pick next cycle's ready
  always @(posedge clk) begin
    if (rst) begin
      segment_ready <= 1'b0;
    end else begin
      if (segment_valid && segment_ready) check_segment(segment);
      segment_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (vertex_valid && vertex_ready) || (segment_valid && segment_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    pot_pkg::in_beat_t  b;
    int                 n, k, r, random_fed;
    logic               narrow;
    pot_pkg::out_beat_t none;

    none          = '0;
    in_polygon    = 1'b0;
    first_x       = '0;
    first_y       = '0;
    prev_x        = '0;
    prev_y        = '0;
    held_scale    = '0;
    held_angle    = '0;
    held_center_x = '0;
    held_center_y = '0;
    held_color    = '0;

    // lone vertices: zero scale puts the point on the center
    add_row(vtx(0, 0, 0, 0, 0, 0, 32'h0, 1'b1), 1'b1, seg(0, 0, 0, 0, 32'h0, 1'b1), none);
    add_row(vtx(32767, -32768, 0, 65535, 32767, -32768, 32'hFFFFFFFF, 1'b1), 1'b1,
            seg(32767, -32768, 32767, -32768, 32'hFFFFFFFF, 1'b1), none);
    // saturating high, later parameters ignored
    add_row(vtx(32767, 32767, 4095, 0, 32767, 32767, 32'hC3A55A3C, 1'b0), 1'b1, none, none);
    add_row(vtx(32767, 32767, 0, 32768, -32768, -32768, 32'h0, 1'b0), 1'b1,
            seg(32767, 32767, 32767, 32767, 32'hC3A55A3C, 1'b0), none);
    add_row(vtx(16384, 32767, 1, 16384, 0, 0, 32'h12345678, 1'b1), 1'b1,
            seg(32767, 32767, 32767, 32767, 32'hC3A55A3C, 1'b0),
            seg(32767, 32767, 32767, 32767, 32'hC3A55A3C, 1'b1));
    // saturating low
    add_row(vtx(-32768, -32768, 4095, 0, -32768, -32768, 32'h0F0FF0F0, 1'b0), 1'b1, none, none);
    add_row(vtx(-20000, -32768, 7, 49152, 32767, 32767, 32'hFFFFFFFF, 1'b0), 1'b1,
            seg(-32768, -32768, -32768, -32768, 32'h0F0FF0F0, 1'b0), none);
    add_row(vtx(-32768, -16000, 4095, 100, 5, 5, 32'h0, 1'b1), 1'b1,
            seg(-32768, -32768, -32768, -32768, 32'h0F0FF0F0, 1'b0),
            seg(-32768, -32768, -32768, -32768, 32'h0F0FF0F0, 1'b1));
    // quarter turn square
    add_row(vtx(256, 0, 256, 16384, 0, 0, 32'hFF0000FF, 1'b0), 1'b0, none, none);
    add_row(vtx(0, 256, 0, 0, 0, 0, 32'h0, 1'b0), 1'b0, none, none);
    add_row(vtx(-256, 0, 0, 0, 0, 0, 32'h0, 1'b0), 1'b0, none, none);
    add_row(vtx(0, -256, 0, 0, 0, 0, 32'h0, 1'b1), 1'b0, none, none);
    // half turn, second vertex carries different parameters
    add_row(vtx(1000, -700, 128, 32768, 400, -400, 32'h00FF00FF, 1'b0), 1'b0, none, none);
    add_row(vtx(-1500, 300, 4095, 12345, -9000, 9000, 32'hDEADBEEF, 1'b1), 1'b0, none, none);
    // three quarter turn triangle
    add_row(vtx(512, 512, 511, 49152, -1000, 2000, 32'h80808080, 1'b0), 1'b0, none, none);
    add_row(vtx(-512, 512, 511, 49152, -1000, 2000, 32'h80808080, 1'b0), 1'b0, none, none);
    add_row(vtx(0, -724, 511, 49152, -1000, 2000, 32'h80808080, 1'b1), 1'b0, none, none);
    // just short of a full turn, largest scale
    add_row(vtx(300, 200, 4095, 65535, 3000, -3000, 32'h7F7F7F7F, 1'b0), 1'b0, none, none);
    add_row(vtx(-300, 100, 4095, 65535, 3000, -3000, 32'h7F7F7F7F, 1'b1), 1'b0, none, none);
    add_row(vtx(4000, -2000, 291, 8192, 1234, -4321, 32'h01020304, 1'b1), 1'b0, none, none);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (r = 0; r < stim_table.size(); r++) begin
      feed(stim_table[r].beat, stim_table[r].typed, stim_table[r].seg_a, stim_table[r].seg_b);
    end

    random_fed = 0;
    while (random_fed < RANDOM_ITEMS) begin
      r = $urandom_range(99);
      n = (r < 15) ? 1 : (r < 85) ? $urandom_range(2, 5) : $urandom_range(6, 12);
      narrow = ($urandom_range(3) != 0);
      for (k = 0; k < n; k++) begin
        // later vertices carry junk parameters that must be ignored
        b.vertex_x   = 16'($urandom);
        b.vertex_y   = 16'($urandom);
        b.scale      = 12'($urandom);
        b.angle      = 16'($urandom);
        b.center_x   = 16'($urandom);
        b.center_y   = 16'($urandom);
        b.line_color = $urandom;
        b.is_last    = (k == n - 1);
        if (narrow) begin
          b.vertex_x = 16'(int'($urandom_range(8191)) - 4096);
          b.vertex_y = 16'(int'($urandom_range(8191)) - 4096);
          if (k == 0) begin
            b.scale    = 12'($urandom_range(768));
            b.center_x = 16'(int'($urandom_range(16383)) - 8192);
            b.center_y = 16'(int'($urandom_range(16383)) - 8192);
          end
        end
        feed(b, 1'b0, none, none);
        random_fed++;
      end
    end

    vertex_valid <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pot_pkg.sv
rtl/pot_front.sv
rtl/pot_queue.sv
rtl/pot_back.sv
rtl/polygon_outline_transform.sv
sim/polygon_outline_transform_tb.sv
